@@ rtl/itor_pkg.sv @@
// itor_pkg: shared types, constants and the Roman weight table for the
// integer-to-Roman encoder. No dependencies.
package itor_pkg;

  localparam int unsigned MaxThousands = 3;
  localparam int unsigned ValueW       = 12;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned WeightW      = 10;

  // Largest value that still converts.
  localparam logic [ValueW:0] MaxValue = (ValueW + 1)'(MaxThousands * 1000 + 999);

  // Index of the last table entry (weight 1, 'I').
  localparam logic [IdxW-1:0] IdxLast = IdxW'(12);

  localparam logic [7:0] AsciiNone = 8'h00;
  localparam logic [7:0] AsciiM    = 8'h4D;
  localparam logic [7:0] AsciiD    = 8'h44;
  localparam logic [7:0] AsciiC    = 8'h43;
  localparam logic [7:0] AsciiL    = 8'h4C;
  localparam logic [7:0] AsciiX    = 8'h58;
  localparam logic [7:0] AsciiV    = 8'h56;
  localparam logic [7:0] AsciiI    = 8'h49;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [7:0]         sym_a;   // first (or only) character
    logic [7:0]         sym_b;   // second character of a subtractive pair
    logic               pair;
  } itor_entry_t;

  // Result of one compare/subtract step.
  typedef struct packed {
    logic              ge;
    logic [ValueW-1:0] diff;
    logic [7:0]        sym_a;
    logic [7:0]        sym_b;
    logic              pair;
  } itor_step_t;

  // Greedy table in descending weight order.
  function automatic itor_entry_t itor_entry(input logic [IdxW-1:0] idx);
    itor_entry_t e;
    e = '{weight: WeightW'(1), sym_a: AsciiI, sym_b: AsciiNone, pair: 1'b0};
    unique case (idx)
      4'd0:    e = '{WeightW'(1000), AsciiM, AsciiNone, 1'b0};
      4'd1:    e = '{WeightW'(900),  AsciiC, AsciiM,    1'b1};
      4'd2:    e = '{WeightW'(500),  AsciiD, AsciiNone, 1'b0};
      4'd3:    e = '{WeightW'(400),  AsciiC, AsciiD,    1'b1};
      4'd4:    e = '{WeightW'(100),  AsciiC, AsciiNone, 1'b0};
      4'd5:    e = '{WeightW'(90),   AsciiX, AsciiC,    1'b1};
      4'd6:    e = '{WeightW'(50),   AsciiL, AsciiNone, 1'b0};
      4'd7:    e = '{WeightW'(40),   AsciiX, AsciiL,    1'b1};
      4'd8:    e = '{WeightW'(10),   AsciiX, AsciiNone, 1'b0};
      4'd9:    e = '{WeightW'(9),    AsciiI, AsciiX,    1'b1};
      4'd10:   e = '{WeightW'(5),    AsciiV, AsciiNone, 1'b0};
      4'd11:   e = '{WeightW'(4),    AsciiI, AsciiV,    1'b1};
      default: e = '{WeightW'(1),    AsciiI, AsciiNone, 1'b0};
    endcase
    return e;
  endfunction

endpackage

@@ rtl/itor_step.sv @@
// itor_step: shared compare/subtract unit; compares the remainder against
// one table weight. Depends on itor_pkg.
module itor_step import itor_pkg::*; (
  input  logic [ValueW-1:0] rem_i,
  input  logic [IdxW-1:0]   idx_i,
  output itor_step_t        step_o
);

  itor_entry_t       entry;
  logic [ValueW-1:0] weight_ext;

  assign entry      = itor_entry(idx_i);
  assign weight_ext = ValueW'(entry.weight);

  always_comb begin
    step_o.ge    = (rem_i >= weight_ext);
    step_o.diff  = rem_i - weight_ext;
    step_o.sym_a = entry.sym_a;
    step_o.sym_b = entry.sym_b;
    step_o.pair  = entry.pair;
  end

endmodule

@@ rtl/integer_to_roman_encoder.sv @@
// integer_to_roman_encoder: top level, sequencer around one shared
// compare/subtract unit. Depends on itor_pkg and itor_step.
//
// Usage:
//   Input channel: drive value_i and raise start_i; the item is taken at a
//   rising edge where start_i is high and busy_o is low.
//   Result channel: each result is shown for one cycle with valid_o high:
//   symbol_o (ASCII char), last_o, empty_res_o, out_of_range_o. The
//   receiver cannot stall; every result must be taken in its cycle.
//   Zero and too-large values give one flagged result the cycle after the
//   item is taken, and busy_o stays low, so such items can come every cycle.
//   Other values: the sequencer walks a 13-entry weight table (M, CM, D,
//   CD, ... IV, I). Each cycle the shared unit compares the remainder to
//   one weight: a match emits a character and subtracts, a miss moves to
//   the next entry. A subtractive pair emits its first character in S_RUN
//   and its second in S_PAIR, which subtracts. busy_o stays high through
//   every character and skipped entry (3888 has the most: 15 characters).
//   The first result shows in the cycle after the first match; the last
//   result shows in the cycle where busy_o is low again, so the next item
//   can be taken at its end. No item is taken while busy_o is high.
//   Reset (rst_ni low, async) returns the sequencer to idle and drops
//   valid_o; an item in flight is lost.
module integer_to_roman_encoder import itor_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              busy_o,
  output logic              valid_o,
  output logic [7:0]        symbol_o,
  output logic              last_o,
  output logic              empty_res_o,
  output logic              out_of_range_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,  // compare, emit single char or first of a pair
    S_PAIR = 3'b100   // emit second char of a pair and subtract
  } state_e;

  state_e            state_q, state_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              valid_q, valid_d;
  logic [7:0]        sym_q, sym_d;
  logic              last_q, last_d;
  logic              empty_q, empty_d;
  logic              oor_q, oor_d;

  logic              accept;
  logic              is_zero;
  logic              is_oor;
  itor_step_t        step;

  itor_step u_step (
    .rem_i  (rem_q),
    .idx_i  (idx_q),
    .step_o (step)
  );

  assign accept  = start_i && (state_q == S_IDLE);
  assign is_zero = (value_i == '0);
  assign is_oor  = ({1'b0, value_i} > MaxValue);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    valid_d = 1'b0;
    sym_d   = AsciiNone;
    last_d  = 1'b0;
    empty_d = 1'b0;
    oor_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_zero || is_oor) begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            empty_d = is_zero;
            oor_d   = is_oor;
          end else begin
            rem_d   = value_i;
            idx_d   = '0;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (step.ge) begin
          valid_d = 1'b1;
          sym_d   = step.sym_a;
          if (step.pair) begin
            state_d = S_PAIR;
          end else begin
            rem_d = step.diff;
            if (step.diff == '0) begin
              last_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end else if (idx_q != IdxLast) begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_PAIR: begin
        valid_d = 1'b1;
        sym_d   = step.sym_b;
        rem_d   = step.diff;
        // a pair entry never repeats, so move on
        if (idx_q != IdxLast) begin
          idx_d = idx_q + 1'b1;
        end
        if (step.diff == '0) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RUN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    sym_q   <= sym_d;
    last_q  <= last_d;
    empty_q <= empty_d;
    oor_q   <= oor_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign symbol_o       = sym_q;
  assign last_o         = last_q;
  assign empty_res_o    = empty_q;
  assign out_of_range_o = oor_q;

`ifndef SYNTH
  // flagged results carry no character and close the run
  a_flag_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (empty_res_o || out_of_range_o) |-> last_o && (symbol_o == AsciiNone))
    else $error("flagged result not a lone last result");

  // character results always carry a character
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !empty_res_o && !out_of_range_o |-> (symbol_o != AsciiNone))
    else $error("character result without character");

  // a convertible item starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !is_zero && !is_oor |=> busy_o)
    else $error("sequencer did not start");

  // the run ends exactly when the last character goes out
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && valid_d && last_d |=> !busy_o && valid_o && last_o)
    else $error("run end and last result disagree");
`endif

endmodule

@@ dv/integer_to_roman_encoder_tb.sv @@
// integer_to_roman_encoder_tb: self-checking bench for the integer-to-Roman encoder.
// It runs a short directed sweep and then random values, and checks every result against
// its row or a local numeral builder. Depends on itor_pkg and the encoder RTL.
module integer_to_roman_encoder_tb import itor_pkg::*;;

  // One result of the encoder, in port order.
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       empty_res;
    logic       out_of_range;
  } roman_res_t;

  // One value to send. When known is set, the single result is written out in the
  // row itself (zero, out of range, the smallest value). Otherwise the numeral
  // builder works it out.
  typedef struct {
    logic [ValueW-1:0] value;
    bit                known;
    logic [7:0]        symbol;
    logic              last;
    logic              empty_res;
    logic              out_of_range;
    int unsigned       gap;
  } numeral_row_t;

  localparam int unsigned RandomItems = 350;
  localparam int unsigned TailItems   = 40;     // final stretch runs with no idle cycles
  localparam int unsigned MaxChars    = 15;
  localparam int unsigned DrainCycles = 40;     // above one worst-case table walk
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SweepRows   = 25;

  logic              clk_i;
  logic              rst_ni  = 1'b0;
  logic              start_i = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy_o;
  logic              valid_o;
  logic [7:0]        symbol_o;
  logic              last_o;
  logic              empty_res_o;
  logic              out_of_range_o;

  roman_res_t   roman_q[$];    // results still owed by the encoder, oldest first
  numeral_row_t pending_q[$];  // the value being offered, popped when it is taken
  int unsigned  err_cnt   = 0;
  int unsigned  item_cnt  = 0;
  int unsigned  char_cnt  = 0;
  int unsigned  flag_cnt  = 0;
  int unsigned  cycle_cnt = 0;

  // Directed sweep: zero and out-of-range back to back, the smallest and largest
  // numerals, every subtractive pair and every digit shape. The alternating bit
  // patterns toggle every bit of value_i.
  numeral_row_t sweep_rows [SweepRows] = '{
    '{12'd0,    1'b1, AsciiNone, 1'b1, 1'b1, 1'b0, 0},
    '{12'd0,    1'b1, AsciiNone, 1'b1, 1'b1, 1'b0, 0},
    '{12'd4000, 1'b1, AsciiNone, 1'b1, 1'b0, 1'b1, 0},
    '{12'd4095, 1'b1, AsciiNone, 1'b1, 1'b0, 1'b1, 0},
    '{12'd0,    1'b1, AsciiNone, 1'b1, 1'b1, 1'b0, 0},
    '{12'd1,    1'b1, AsciiI,    1'b1, 1'b0, 1'b0, 0},
    '{12'd4,    1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd5,    1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 3},
    '{12'd9,    1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd10,   1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd40,   1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd49,   1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 2},
    '{12'd90,   1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd99,   1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd400,  1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd444,  1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd500,  1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 5},
    '{12'd900,  1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd999,  1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd1000, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd3000, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd3888, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd3999, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 1},
    '{12'd2730, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0},
    '{12'd1365, 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0}
  };

  integer_to_roman_encoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .value_i        (value_i),
    .busy_o         (busy_o),
    .valid_o        (valid_o),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .empty_res_o    (empty_res_o),
    .out_of_range_o (out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (item %0d, cycle %0d)",
             what, want, got, item_cnt, cycle_cnt);
    err_cnt++;
  endtask

  // Build the numeral for one value and queue its characters. Thousands come
  // as repeated M. Each lower digit uses its one/five/ten letters: 9 and 4
  // take the subtractive pair, 5..8 a five letter and then ones, the rest only
  // ones. Zero and values past the thousands bound give one flagged result.
  function automatic void encode_roman(input logic [ValueW-1:0] v);
    int unsigned thousands;
    int unsigned rem;
    int unsigned d;
    logic [7:0]  ones;
    logic [7:0]  fives;
    logic [7:0]  tens;
    logic [7:0]  chars[$];
    thousands = v / 1000;
    rem = v % 1000;
    if (v == 0 || thousands > MaxThousands) begin
      roman_q.push_back('{AsciiNone, 1'b1, v == 0, v != 0});
      return;
    end
    repeat (thousands) chars.push_back(AsciiM);
    for (int pos = 0; pos < 3; pos++) begin
      case (pos)
        0: begin
          d = rem / 100;
          ones = AsciiC; fives = AsciiD; tens = AsciiM;
        end
        1: begin
          d = (rem / 10) % 10;
          ones = AsciiX; fives = AsciiL; tens = AsciiC;
        end
        default: begin
          d = rem % 10;
          ones = AsciiI; fives = AsciiV; tens = AsciiX;
        end
      endcase
      if (d == 9) begin
        chars.push_back(ones);
        chars.push_back(tens);
      end else if (d == 4) begin
        chars.push_back(ones);
        chars.push_back(fives);
      end else begin
        if (d >= 5) begin
          chars.push_back(fives);
          d -= 5;
        end
        repeat (d) chars.push_back(ones);
      end
    end
    // The run is capped at the result limit. A legal value never exceeds it.
    while (chars.size() > MaxChars) void'(chars.pop_back());
    foreach (chars[k]) roman_q.push_back('{chars[k], k == chars.size() - 1, 1'b0, 1'b0});
  endfunction

  // Random value mix: mostly plain legal values, then values built from long or
  // subtractive digits (4, 9, 8, 3, 7), values past the bound, zeros, and any
  // 12-bit value.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned sel;
    int unsigned v;
    int unsigned digs[5] = '{4, 9, 8, 3, 7};
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      v = $urandom_range(1, MaxThousands * 1000 + 999);
    end else if (sel < 75) begin
      v = $urandom_range(0, MaxThousands) * 1000 + digs[$urandom_range(0, 4)] * 100
        + digs[$urandom_range(0, 4)] * 10 + digs[$urandom_range(0, 4)];
    end else if (sel < 85) begin
      v = $urandom_range(MaxThousands * 1000 + 1000, (1 << ValueW) - 1);
    end else if (sel < 92) begin
      v = 0;
    end else begin
      v = $urandom_range(0, (1 << ValueW) - 1);
    end
    return v[ValueW-1:0];
  endfunction

  // Offer one value and hold it until the encoder takes it. An optional idle
  // burst comes first. With no burst, start_i stays high from the previous
  // item and only value_i changes.
  task automatic send_value(input numeral_row_t row);
    if (row.gap != 0) begin
      start_i <= 1'b0;
      repeat (row.gap) @(posedge clk_i);
    end
    pending_q.push_back(row);
    start_i <= 1'b1;
    value_i <= row.value;
    do @(posedge clk_i); while (!(start_i && !busy_o));
  endtask

  // Result check and capture of accepted items, both on pre-edge values.
  // An item taken at this edge queues its expectation after the check, so
  // a result of that item can never match at the same edge.
  always @(posedge clk_i) begin
    roman_res_t   got;
    roman_res_t   want;
    numeral_row_t row;
    if (rst_ni) begin
      if (valid_o) begin
        got = '{symbol_o, last_o, empty_res_o, out_of_range_o};
        if (got.empty_res || got.out_of_range) flag_cnt++;
        else char_cnt++;
        if (roman_q.size() == 0) begin
          report_mismatch("result with nothing pending, symbol", 0, got.symbol);
        end else begin
          want = roman_q.pop_front();
          if (got.symbol !== want.symbol) report_mismatch("symbol", want.symbol, got.symbol);
          if (got.last !== want.last) report_mismatch("last", want.last, got.last);
          if (got.empty_res !== want.empty_res) begin
            report_mismatch("empty_res", want.empty_res, got.empty_res);
          end
          if (got.out_of_range !== want.out_of_range) begin
            report_mismatch("out_of_range", want.out_of_range, got.out_of_range);
          end
        end
      end
      if (start_i && !busy_o && pending_q.size() != 0) begin
        row = pending_q.pop_front();
        item_cnt++;
        if (row.known) begin
          roman_q.push_back('{row.symbol, row.last, row.empty_res, row.out_of_range});
        end else begin
          encode_roman(value_i);
        end
      end
    end
  end

  // Safety net against a hung handshake or a lost result.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, roman_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    numeral_row_t row;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (sweep_rows[i]) send_value(sweep_rows[i]);

    // Random part. Idle bursts are sparse so that long busy stretches remain.
    // The last stretch runs with no idle cycles at all.
    for (int n = 0; n < RandomItems; n++) begin
      row = '{pick_value(), 1'b0, AsciiNone, 1'b0, 1'b0, 1'b0, 0};
      if (n < RandomItems - TailItems && $urandom_range(0, 3) == 0) begin
        row.gap = $urandom_range(1, 11);
      end
      send_value(row);
    end
    start_i <= 1'b0;

    while (roman_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    // anything still owed after the drain is a lost result
    if (roman_q.size() != 0) report_mismatch("results never seen, count", 0, roman_q.size());

    $display("covered %0d values (%0d directed): %0d characters, %0d zero/out-of-range results",
             item_cnt, SweepRows, char_cnt, flag_cnt);
    $display("mismatches: %0d over %0d cycles", err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
